// ===== rtl/tmprof_pkg.sv =====
// Shared constants and types for the trapezoid motion profile.
package tmprof_pkg;

    localparam int TMPROF_FRAC_BITS = 16;
    localparam int TMPROF_WORD_BITS = 32;
    localparam int CFG_IDX_BITS     = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_DISTANCE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_SPEED  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_SPEED    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_SPEED = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACCELERATION = 3'd4;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [4:0] {
        PL_S0,
        PL_SN,
        PL_AD,
        PL_SC,
        PL_SUM,
        PL_CMP,
        PL_TOT,
        PL_SPLIT,
        PL_SQRT,
        PL_VPSQ,
        PL_DIVGO,
        PL_DIV,
        PL_CRU,
        PL_T2,
        PL_IDLE
    } t_plan_state;

    typedef enum logic [1:0] {
        MD_UP,
        MD_DOWN,
        MD_TRI,
        MD_FULL
    } t_mode;

    typedef enum logic [2:0] {
        DS_DACC,
        DS_DDEC,
        DS_T1,
        DS_TC,
        DS_T3
    } t_dsel;

endpackage

// ===== rtl/tmprof_plan.sv =====
// Move planner: works out phase times, ramp distances and end speed from the configuration.
module tmprof_plan #(
    parameter int FRAC_BITS = tmprof_pkg::TMPROF_FRAC_BITS,
    parameter int WORD_BITS = tmprof_pkg::TMPROF_WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_distance,
    input  logic [WORD_BITS-1:0] i_start_speed,
    input  logic [WORD_BITS-1:0] i_end_speed,
    input  logic [WORD_BITS-1:0] i_target_speed,
    input  logic [WORD_BITS-1:0] i_acceleration,
    output logic                 o_busy,
    output logic                 o_reach,
    output logic [WORD_BITS-1:0] o_vp,
    output logic [WORD_BITS-1:0] o_vend,
    output logic [WORD_BITS-1:0] o_dacc,
    output logic [WORD_BITS-1:0] o_base2,
    output logic [WORD_BITS:0]   o_t1,
    output logic [WORD_BITS:0]   o_t2,
    output logic [WORD_BITS:0]   o_t3
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int NW = 2 * WORD_BITS;
    localparam int CW = $clog2(2 * WORD_BITS);
    localparam logic [W:0]    TSAT   = {1'b1, W'(0)};
    localparam logic [NW-1:0] TSAT_Q = {(W-1)'(0), 1'b1, W'(0)};

    tmprof_pkg::t_plan_state r_state, n_state;
    tmprof_pkg::t_mode       r_mode, n_mode;
    tmprof_pkg::t_dsel       r_dsel, n_dsel;

    logic          r_reach, n_reach;
    logic [NW-1:0] r_s0, n_s0, r_sn, n_sn, r_scap, n_scap;
    logic [NW:0]   r_ad2, n_ad2;
    logic [NW+1:0] r_up, n_up, r_dn, n_dn, r_tot, n_tot;
    logic [W-1:0]  r_vp, n_vp, r_vend, n_vend, r_dacc, n_dacc, r_ddec, n_ddec;
    logic [W-1:0]  r_dcru, n_dcru;
    logic [W:0]    r_t1, n_t1, r_tc, n_tc, r_t2, n_t2, r_t3, n_t3;
    logic [NW-1:0] r_rad, n_rad;
    logic [W+1:0]  r_srem, n_srem;
    logic [W-1:0]  r_root, n_root;
    logic [NW-1:0] r_num, n_num, r_quo, n_quo;
    logic [W-1:0]  r_den, n_den, r_drem, n_drem;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [W-1:0]  acc, vt, vcap, vnc, dv_up, dv_dn, mul_a, mul_b;
    logic          clamp;
    logic [NW-1:0] prod, num_go, quo_nx;
    logic [W-1:0]  den_go, q_sat_d, drem_nx;
    logic [W:0]    dsh, q_sat_t, dd_sum;
    logic          dge, sge;
    logic [W+3:0]  ssh, strial;
    logic [W+1:0]  srem_nx;
    logic [W-1:0]  root_nx;
    logic [W+1:0]  t2s, t3s;

    assign acc   = (i_acceleration == '0) ? W'(1) : i_acceleration;
    assign vt    = (i_target_speed == '0) ? W'(1) : i_target_speed;
    assign vcap  = (vt > i_start_speed) ? vt : i_start_speed;
    assign clamp = (i_end_speed > vcap);
    assign vnc   = clamp ? vcap : i_end_speed;
    assign dv_up = (r_vp >= i_start_speed) ? r_vp - i_start_speed : '0;
    assign dv_dn = (r_vp >= r_vend) ? r_vp - r_vend : '0;

    always_comb begin
        case (r_state)
            tmprof_pkg::PL_S0: begin
                mul_a = i_start_speed;
                mul_b = i_start_speed;
            end
            tmprof_pkg::PL_SN: begin
                mul_a = vnc;
                mul_b = vnc;
            end
            tmprof_pkg::PL_AD: begin
                mul_a = acc;
                mul_b = i_distance;
            end
            tmprof_pkg::PL_SC: begin
                mul_a = vcap;
                mul_b = vcap;
            end
            tmprof_pkg::PL_VPSQ: begin
                mul_a = r_vp;
                mul_b = r_vp;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = NW'(mul_a) * NW'(mul_b);

    always_comb begin
        case (r_dsel)
            tmprof_pkg::DS_DACC: begin
                num_go = (r_scap >= r_s0) ? (r_scap - r_s0) >> 1 : '0;
                den_go = acc;
            end
            tmprof_pkg::DS_DDEC: begin
                num_go = (r_scap - r_sn) >> 1;
                den_go = acc;
            end
            tmprof_pkg::DS_T1: begin
                num_go = NW'(dv_up) << F;
                den_go = acc;
            end
            tmprof_pkg::DS_TC: begin
                num_go = NW'(r_dcru) << F;
                den_go = r_vp;
            end
            default: begin
                num_go = NW'(dv_dn) << F;
                den_go = acc;
            end
        endcase
    end

    // Restoring divider, one quotient bit per cycle.
    assign dsh     = {r_drem, r_num[NW-1]};
    assign dge     = (dsh >= {1'b0, r_den});
    assign drem_nx = dge ? W'(dsh - {1'b0, r_den}) : dsh[W-1:0];
    assign quo_nx  = {r_quo[NW-2:0], dge};
    assign q_sat_d = (quo_nx > NW'(i_distance)) ? i_distance : quo_nx[W-1:0];
    assign q_sat_t = (quo_nx > TSAT_Q) ? TSAT : quo_nx[W:0];

    // Square root, one result bit per cycle.
    assign ssh     = {r_srem, r_rad[NW-1 -: 2]};
    assign strial  = {2'b00, r_root, 2'b01};
    assign sge     = (ssh >= strial);
    assign srem_nx = sge ? (W+2)'(ssh - strial) : ssh[W+1:0];
    assign root_nx = {r_root[W-2:0], sge};

    assign dd_sum = (W+1)'(r_dacc) + (W+1)'(r_ddec);
    assign t2s    = (W+2)'(r_t1) + (W+2)'(r_tc);
    assign t3s    = (W+2)'(r_t2) + (W+2)'(q_sat_t);

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_dsel  = r_dsel;
        n_reach = r_reach;
        n_s0    = r_s0;
        n_sn    = r_sn;
        n_scap  = r_scap;
        n_ad2   = r_ad2;
        n_up    = r_up;
        n_dn    = r_dn;
        n_tot   = r_tot;
        n_vp    = r_vp;
        n_vend  = r_vend;
        n_dacc  = r_dacc;
        n_ddec  = r_ddec;
        n_dcru  = r_dcru;
        n_t1    = r_t1;
        n_tc    = r_tc;
        n_t2    = r_t2;
        n_t3    = r_t3;
        n_rad   = r_rad;
        n_srem  = r_srem;
        n_root  = r_root;
        n_num   = r_num;
        n_den   = r_den;
        n_drem  = r_drem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        case (r_state)
            tmprof_pkg::PL_S0: begin
                n_s0    = prod;
                n_reach = !clamp;
                n_state = tmprof_pkg::PL_SN;
            end
            tmprof_pkg::PL_SN: begin
                n_sn    = prod;
                n_state = tmprof_pkg::PL_AD;
            end
            tmprof_pkg::PL_AD: begin
                n_ad2   = {prod, 1'b0};
                n_state = tmprof_pkg::PL_SC;
            end
            tmprof_pkg::PL_SC: begin
                n_scap  = prod;
                n_state = tmprof_pkg::PL_SUM;
            end
            tmprof_pkg::PL_SUM: begin
                n_up    = (NW+2)'(r_s0) + (NW+2)'(r_ad2);
                n_dn    = (NW+2)'(r_sn) + (NW+2)'(r_ad2);
                n_state = tmprof_pkg::PL_CMP;
            end
            tmprof_pkg::PL_CMP: begin
                n_srem = '0;
                n_root = '0;
                n_cnt  = CW'(W - 1);
                if (r_up < (NW+2)'(r_sn)) begin
                    n_rad   = r_up[NW-1:0];
                    n_mode  = tmprof_pkg::MD_UP;
                    n_reach = 1'b0;
                    n_state = tmprof_pkg::PL_SQRT;
                end else if (r_dn < (NW+2)'(r_s0)) begin
                    n_rad   = r_s0 - NW'(r_ad2);
                    n_mode  = tmprof_pkg::MD_DOWN;
                    n_reach = 1'b0;
                    n_state = tmprof_pkg::PL_SQRT;
                end else begin
                    n_state = tmprof_pkg::PL_TOT;
                end
            end
            tmprof_pkg::PL_TOT: begin
                n_tot   = r_up + (NW+2)'(r_sn);
                n_vend  = vnc;
                n_dcru  = '0;
                n_state = tmprof_pkg::PL_SPLIT;
            end
            tmprof_pkg::PL_SPLIT: begin
                if ({1'b0, r_scap, 1'b0} <= r_tot) begin
                    n_vp    = vcap;
                    n_mode  = tmprof_pkg::MD_FULL;
                    n_dsel  = tmprof_pkg::DS_DACC;
                    n_state = tmprof_pkg::PL_DIVGO;
                end else begin
                    n_rad   = r_tot[NW:1];
                    n_mode  = tmprof_pkg::MD_TRI;
                    n_state = tmprof_pkg::PL_SQRT;
                end
            end
            tmprof_pkg::PL_SQRT: begin
                n_srem = srem_nx;
                n_root = root_nx;
                n_rad  = r_rad << 2;
                n_cnt  = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    case (r_mode)
                        tmprof_pkg::MD_UP: begin
                            n_vp    = root_nx;
                            n_vend  = root_nx;
                            n_dacc  = i_distance;
                            n_dcru  = '0;
                            n_dsel  = tmprof_pkg::DS_T1;
                            n_state = tmprof_pkg::PL_DIVGO;
                        end
                        tmprof_pkg::MD_DOWN: begin
                            n_vp    = i_start_speed;
                            n_vend  = root_nx;
                            n_dacc  = '0;
                            n_dcru  = '0;
                            n_dsel  = tmprof_pkg::DS_T1;
                            n_state = tmprof_pkg::PL_DIVGO;
                        end
                        default: begin
                            n_vp    = root_nx;
                            n_state = tmprof_pkg::PL_VPSQ;
                        end
                    endcase
                end
            end
            tmprof_pkg::PL_VPSQ: begin
                n_scap  = prod;
                n_dsel  = tmprof_pkg::DS_DACC;
                n_state = tmprof_pkg::PL_DIVGO;
            end
            tmprof_pkg::PL_DIVGO: begin
                n_num   = num_go;
                n_den   = den_go;
                n_drem  = '0;
                n_quo   = '0;
                n_cnt   = CW'(NW - 1);
                n_state = tmprof_pkg::PL_DIV;
            end
            tmprof_pkg::PL_DIV: begin
                n_num  = r_num << 1;
                n_drem = drem_nx;
                n_quo  = quo_nx;
                n_cnt  = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    case (r_dsel)
                        tmprof_pkg::DS_DACC: begin
                            n_dacc = q_sat_d;
                            if (r_mode == tmprof_pkg::MD_TRI) begin
                                n_dsel = tmprof_pkg::DS_T1;
                            end else begin
                                n_dsel = tmprof_pkg::DS_DDEC;
                            end
                            n_state = tmprof_pkg::PL_DIVGO;
                        end
                        tmprof_pkg::DS_DDEC: begin
                            n_ddec  = q_sat_d;
                            n_state = tmprof_pkg::PL_CRU;
                        end
                        tmprof_pkg::DS_T1: begin
                            n_t1 = q_sat_t;
                            if (r_dcru != '0 && r_vp != '0) begin
                                n_dsel  = tmprof_pkg::DS_TC;
                                n_state = tmprof_pkg::PL_DIVGO;
                            end else begin
                                n_tc    = '0;
                                n_state = tmprof_pkg::PL_T2;
                            end
                        end
                        tmprof_pkg::DS_TC: begin
                            n_tc    = q_sat_t;
                            n_state = tmprof_pkg::PL_T2;
                        end
                        default: begin
                            n_t3    = (t3s > (W+2)'(TSAT)) ? TSAT : t3s[W:0];
                            n_state = tmprof_pkg::PL_IDLE;
                        end
                    endcase
                end
            end
            tmprof_pkg::PL_CRU: begin
                n_dcru  = (dd_sum <= {1'b0, i_distance}) ?
                          i_distance - r_dacc - r_ddec : '0;
                n_dsel  = tmprof_pkg::DS_T1;
                n_state = tmprof_pkg::PL_DIVGO;
            end
            tmprof_pkg::PL_T2: begin
                n_t2    = (t2s > (W+2)'(TSAT)) ? TSAT : t2s[W:0];
                n_dsel  = tmprof_pkg::DS_T3;
                n_state = tmprof_pkg::PL_DIVGO;
            end
            default: begin
                n_state = tmprof_pkg::PL_IDLE;
            end
        endcase
        if (i_start) begin
            n_state = tmprof_pkg::PL_S0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmprof_pkg::PL_S0;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_dsel  <= n_dsel;
        r_reach <= n_reach;
        r_s0    <= n_s0;
        r_sn    <= n_sn;
        r_scap  <= n_scap;
        r_ad2   <= n_ad2;
        r_up    <= n_up;
        r_dn    <= n_dn;
        r_tot   <= n_tot;
        r_vp    <= n_vp;
        r_vend  <= n_vend;
        r_dacc  <= n_dacc;
        r_ddec  <= n_ddec;
        r_dcru  <= n_dcru;
        r_t1    <= n_t1;
        r_tc    <= n_tc;
        r_t2    <= n_t2;
        r_t3    <= n_t3;
        r_rad   <= n_rad;
        r_srem  <= n_srem;
        r_root  <= n_root;
        r_num   <= n_num;
        r_den   <= n_den;
        r_drem  <= n_drem;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
    end

    assign o_busy  = (r_state != tmprof_pkg::PL_IDLE);
    assign o_reach = r_reach;
    assign o_vp    = r_vp;
    assign o_vend  = r_vend;
    assign o_dacc  = r_dacc;
    assign o_base2 = r_dacc + r_dcru;
    assign o_t1    = r_t1;
    assign o_t2    = r_t2;
    assign o_t3    = r_t3;

endmodule

// ===== rtl/trapezoid_motion_profile.sv =====
// Trapezoid motion profile top level: configuration registers and the sample pipeline.
// One request per cycle while the planner is idle and the output does not stall.
// The sample pipeline has six stages and stalls as a whole when the result is not taken.
// After reset and after every configuration write the planner works out a new plan;
// no request is taken meanwhile.
// Reset is synchronous and active low; only control and configuration registers reset.
module trapezoid_motion_profile #(
    parameter int FRAC_BITS = tmprof_pkg::TMPROF_FRAC_BITS,
    parameter int WORD_BITS = tmprof_pkg::TMPROF_WORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tmprof_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [WORD_BITS-1:0]              i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [WORD_BITS-1:0]              i_sample_time,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [WORD_BITS-1:0]              o_position,
    output logic [1:0]                        o_phase,
    output logic                              o_end_reached,
    output logic [WORD_BITS-1:0]              o_achieved_end_speed
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int LW  = 2 * WORD_BITS + FRAC_BITS + 1;
    localparam int NW5 = 3 * WORD_BITS + 2;
    localparam logic [W-1:0] ONE   = W'(1) << F;
    localparam logic [W-1:0] WMASK = {W{1'b1}};

    logic [W-1:0] r_distance, r_start_speed, r_end_speed, r_target_speed, r_acceleration;
    logic [W-1:0] acc;

    logic         busy, reach;
    logic [W-1:0] vp, vend, dacc, base2;
    logic [W:0]   t1, t2, t3;

    logic                r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v;
    tmprof_pkg::t_phase  r_s1_phase, r_s2_phase, r_s3_phase, r_s4_phase, r_s5_phase;
    tmprof_pkg::t_phase  r_s6_phase, n_s1_phase;
    logic [W-1:0]        r_s1_u, n_s1_u, r_s1_spd, n_s1_spd, r_s2_u;
    logic [2*W-1:0]      r_s2_vu, r_s2_au, r_s3_vu, r_s3_ql, r_s3_qh, r_s4_vu;
    logic [3*W-1:0]      r_s4_quad;
    logic [LW-1:0]       r_s4_lin;
    logic [W-1:0]        r_s5_delta, n_s5_delta, r_s5_base, n_s5_base, r_s5_room;
    logic [W-1:0]        r_s6_pos;

    logic           adv, take;
    logic [W:0]     tx;
    logic [NW5-1:0] lin_x, quad_x, n_sum, n_dif, n_sel, n_sh;
    logic [2*W-1:0] c_sh;
    logic [W-1:0]   ramp_d, cruise_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance     <= '0;
            r_start_speed  <= '0;
            r_end_speed    <= '0;
            r_target_speed <= ONE;
            r_acceleration <= ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tmprof_pkg::REG_DISTANCE:     r_distance     <= i_cfg_data;
                tmprof_pkg::REG_START_SPEED:  r_start_speed  <= i_cfg_data;
                tmprof_pkg::REG_END_SPEED:    r_end_speed    <= i_cfg_data;
                tmprof_pkg::REG_TARGET_SPEED: r_target_speed <= i_cfg_data;
                tmprof_pkg::REG_ACCELERATION: r_acceleration <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign acc = (r_acceleration == '0) ? W'(1) : r_acceleration;

    tmprof_plan #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_plan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_cfg_we),
        .i_distance     (r_distance),
        .i_start_speed  (r_start_speed),
        .i_end_speed    (r_end_speed),
        .i_target_speed (r_target_speed),
        .i_acceleration (r_acceleration),
        .o_busy         (busy),
        .o_reach        (reach),
        .o_vp           (vp),
        .o_vend         (vend),
        .o_dacc         (dacc),
        .o_base2        (base2),
        .o_t1           (t1),
        .o_t2           (t2),
        .o_t3           (t3)
    );

    assign adv        = !r_s6_v || i_out_ready;
    assign o_in_ready = adv && !busy;
    assign take       = i_in_valid && o_in_ready;

    assign tx = {1'b0, i_sample_time};

    always_comb begin
        if (tx < t1) begin
            n_s1_phase = tmprof_pkg::PH_ACCEL;
            n_s1_u     = i_sample_time;
            n_s1_spd   = r_start_speed;
        end else if (tx < t2) begin
            n_s1_phase = tmprof_pkg::PH_CRUISE;
            n_s1_u     = i_sample_time - t1[W-1:0];
            n_s1_spd   = vp;
        end else if (tx <= t3) begin
            n_s1_phase = tmprof_pkg::PH_DECEL;
            n_s1_u     = i_sample_time - t2[W-1:0];
            n_s1_spd   = vp;
        end else begin
            n_s1_phase = tmprof_pkg::PH_DONE;
            n_s1_u     = '0;
            n_s1_spd   = '0;
        end
    end

    assign lin_x  = NW5'(r_s4_lin);
    assign quad_x = NW5'(r_s4_quad);
    assign n_sum  = lin_x + quad_x;
    assign n_dif  = (quad_x > lin_x) ? '0 : lin_x - quad_x;
    assign n_sel  = (r_s4_phase == tmprof_pkg::PH_ACCEL) ? n_sum : n_dif;
    assign n_sh   = n_sel >> (2 * F + 1);
    assign ramp_d = (n_sh > NW5'(WMASK)) ? WMASK : n_sh[W-1:0];
    assign c_sh     = r_s4_vu >> F;
    assign cruise_d = (c_sh > (2*W)'(WMASK)) ? WMASK : c_sh[W-1:0];

    always_comb begin
        case (r_s4_phase)
            tmprof_pkg::PH_ACCEL: begin
                n_s5_delta = ramp_d;
                n_s5_base  = '0;
            end
            tmprof_pkg::PH_CRUISE: begin
                n_s5_delta = cruise_d;
                n_s5_base  = dacc;
            end
            tmprof_pkg::PH_DECEL: begin
                n_s5_delta = ramp_d;
                n_s5_base  = base2;
            end
            default: begin
                n_s5_delta = '0;
                n_s5_base  = r_distance;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= take;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_phase <= n_s1_phase;
            r_s1_u     <= n_s1_u;
            r_s1_spd   <= n_s1_spd;

            r_s2_phase <= r_s1_phase;
            r_s2_u     <= r_s1_u;
            r_s2_vu    <= (2*W)'(r_s1_spd) * (2*W)'(r_s1_u);
            r_s2_au    <= (2*W)'(acc) * (2*W)'(r_s1_u);

            r_s3_phase <= r_s2_phase;
            r_s3_vu    <= r_s2_vu;
            r_s3_ql    <= (2*W)'(r_s2_au[W-1:0]) * (2*W)'(r_s2_u);
            r_s3_qh    <= (2*W)'(r_s2_au[2*W-1:W]) * (2*W)'(r_s2_u);

            r_s4_phase <= r_s3_phase;
            r_s4_vu    <= r_s3_vu;
            r_s4_quad  <= ((3*W)'(r_s3_qh) << W) + (3*W)'(r_s3_ql);
            r_s4_lin   <= LW'(r_s3_vu) << (F + 1);

            r_s5_phase <= r_s4_phase;
            r_s5_delta <= n_s5_delta;
            r_s5_base  <= n_s5_base;
            r_s5_room  <= r_distance - n_s5_base;

            r_s6_phase <= r_s5_phase;
            r_s6_pos   <= (r_s5_delta >= r_s5_room) ? r_distance : r_s5_base + r_s5_delta;
        end
    end

    assign o_out_valid          = r_s6_v;
    assign o_position           = r_s6_pos;
    assign o_phase              = r_s6_phase;
    assign o_end_reached        = reach;
    assign o_achieved_end_speed = vend;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_position <= r_distance))
        else $error("position beyond the move distance");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_phase == tmprof_pkg::PH_DONE) |-> (o_position == r_distance))
        else $error("finished phase away from the end position");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (t1 <= t2 && t2 <= t3))
        else $error("planned phase times out of order");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !take)
        else $error("request taken while the plan is being worked out");

endmodule
